### hw/rtl/constellation_map_demap_top_assert.svh
// Assertion macros for the constellation mapper/demapper.
// Included by constellation_map_demap_top; no other dependencies.
`ifndef CONSTELLATION_MAP_DEMAP_TOP_ASSERT_SVH
`define CONSTELLATION_MAP_DEMAP_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CMD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/cmd_pkg.sv
// Shared types and constants of the constellation mapper/demapper.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package cmd_pkg;

   localparam int POINT_WIDTH      = 16;
   localparam int SYM_WIDTH        = 4;
   localparam int NUM_POINTS_WIDTH = 5;
   localparam int OP_WIDTH         = 2;
   localparam int INDEX_WIDTH      = 8;

   localparam logic [NUM_POINTS_WIDTH-1:0] NUM_POINTS_RESET = 5'd16;

   // item operation codes
   localparam logic [OP_WIDTH-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_MAP   = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_DEMAP = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_SCAN,
      ST_DONE
   } cmd_state_type;

endpackage

### hw/rtl/cmd_req_if.sv
// Request channel of the constellation mapper/demapper: valid/ready plus item fields.
// Depends on cmd_pkg.
`timescale 1ns / 1ps

interface cmd_req_if
   import cmd_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic [OP_WIDTH-1:0]           op;
   logic [INDEX_WIDTH-1:0]        index;
   logic signed [POINT_WIDTH-1:0] point_re;
   logic signed [POINT_WIDTH-1:0] point_im;
   logic signed [SAMPLE_WIDTH-1:0] sample_re;
   logic signed [SAMPLE_WIDTH-1:0] sample_im;

   modport source (
      output valid, op, index, point_re, point_im, sample_re, sample_im,
      input  ready
   );
   modport sink (
      input  valid, op, index, point_re, point_im, sample_re, sample_im,
      output ready
   );
endinterface

### hw/rtl/cmd_rsp_if.sv
// Response channel of the constellation mapper/demapper: valid/ready plus result fields.
// Depends on cmd_pkg.
`timescale 1ns / 1ps

interface cmd_rsp_if
   import cmd_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [POINT_WIDTH-1:0] mapped_re;
   logic signed [POINT_WIDTH-1:0] mapped_im;
   logic [SYM_WIDTH-1:0]          symbol_index;
   logic                          index_error;

   modport source (
      output valid, mapped_re, mapped_im, symbol_index, index_error,
      input  ready
   );
   modport sink (
      input  valid, mapped_re, mapped_im, symbol_index, index_error,
      output ready
   );
endinterface

### hw/rtl/cmd_csr_if.sv
// Configuration write channel of the constellation mapper/demapper (point count).
// Depends on cmd_pkg.
`timescale 1ns / 1ps

interface cmd_csr_if
   import cmd_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic [NUM_POINTS_WIDTH-1:0] data;

   modport source (
      output valid, data,
      input  ready
   );
   modport sink (
      input  valid, data,
      output ready
   );
endinterface

### hw/rtl/cmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cmd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/constellation_map_demap_top.sv
// Top level of the constellation mapper/demapper: FSM, point table, distance unit.
// Depends on cmd_pkg, cmd_req_if, cmd_rsp_if, cmd_csr_if, cmd_ram and the assert header.
`timescale 1ns / 1ps

// Constellation mapper/demapper. The point table lives in one RAM (re and im side by
// side, one read port, one write port, registered read). Every accepted beat gives
// exactly one response beat. A load goes from idle to done, a map takes its point from
// the RAM in the map state, and a demap scans the M points in use: the distance unit
// (difference, two squarers, add and compare, one pipeline stage each) takes one table
// point per cycle from the RAM read port, so the scan length sets the demap time. The
// block takes one item at a time; while a finished response waits in the output
// register the next item is already accepted. The point count register is written
// over the csr channel, which is always ready and must only be written while idle.

`include "constellation_map_demap_top_assert.svh"

module constellation_map_demap_top
   import cmd_pkg::*;
#(
   parameter int MAX_POINTS   = 16,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   cmd_req_if.sink   req_if,
   cmd_rsp_if.source rsp_if,
   cmd_csr_if.sink   csr_if
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int DW   = ((SAMPLE_WIDTH > POINT_WIDTH) ? SAMPLE_WIDTH : POINT_WIDTH) + 1;
   localparam int SQW  = 2 * DW;
   localparam int DSTW = SQW + 1;
   localparam int RAMW = 2 * POINT_WIDTH;

   cmd_state_type state_ff, state_in;

   logic [NUM_POINTS_WIDTH-1:0] num_points_ff, num_points_in;
   logic [CW-1:0]               eff_m;
   logic                        idx_ok;
   logic                        req_fire, rsp_fire, csr_fire, out_free;

   // RAM controls
   logic            wr_en, rd_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [RAMW-1:0] wr_data, rd_data;

   // scan issue counter and pipeline
   logic [CW-1:0] issue_cnt_ff, issue_cnt_in;
   logic          issue_go;
   logic signed [SAMPLE_WIDTH-1:0] sample_re_ff, sample_re_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_im_ff, sample_im_in;
   logic          v0_ff, v1_ff, v2_ff;
   logic          last0_ff, last1_ff, last2_ff;
   logic [AW-1:0] tag0_ff, tag1_ff, tag2_ff;
   logic signed [DW-1:0] diff_re, diff_im;
   logic [DW-1:0]   abs_re_ff, abs_re_in, abs_im_ff, abs_im_in;
   logic [SQW-1:0]  sq_re_ff, sq_re_in, sq_im_ff, sq_im_in;
   logic [DSTW-1:0] dist_sum;
   logic [DSTW-1:0] best_dist_ff, best_dist_in;
   logic [AW-1:0]   best_idx_ff, best_idx_in;
   logic            take;
   logic [8:0]      sym_wide;

   // held result and output register
   logic signed [POINT_WIDTH-1:0] res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic [SYM_WIDTH-1:0]          res_sym_ff, res_sym_in;
   logic                          res_err_ff, res_err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [POINT_WIDTH-1:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic [SYM_WIDTH-1:0]          rsp_sym_ff, rsp_sym_in;
   logic                          rsp_err_ff, rsp_err_in;

   // clamp the point count to 1..MAX_POINTS
   always_comb begin
      if (num_points_ff == '0) begin
         eff_m = CW'(1);
      end else if (int'(num_points_ff) > MAX_POINTS) begin
         eff_m = CW'(MAX_POINTS);
      end else begin
         eff_m = CW'(num_points_ff);
      end
   end

   assign idx_ok   = (9'(req_if.index) < 9'(eff_m));
   assign req_fire = req_if.valid & req_if.ready;
   assign rsp_fire = rsp_valid_ff & rsp_if.ready;
   assign csr_fire = csr_if.valid & csr_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign issue_go = (state_ff == ST_SCAN) && (issue_cnt_ff < eff_m);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_if.op)
                  OP_MAP:   state_in = idx_ok ? ST_MAP : ST_DONE;
                  OP_DEMAP: state_in = ST_SCAN;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_MAP: state_in = ST_DONE;
         ST_SCAN: begin
            if (v2_ff && last2_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // FSM outputs: handshakes and RAM ports
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      csr_if.ready = 1'b1;
      wr_en        = req_fire && (req_if.op == OP_LOAD) && idx_ok;
      wr_addr      = req_if.index[AW-1:0];
      wr_data      = {req_if.point_re, req_if.point_im};
      if (state_ff == ST_SCAN) begin
         rd_en   = issue_go;
         rd_addr = issue_cnt_ff[AW-1:0];
      end else begin
         rd_en   = req_fire && (req_if.op == OP_MAP) && idx_ok;
         rd_addr = req_if.index[AW-1:0];
      end
   end

   // distance unit: difference, magnitude, squares, sum and compare
   always_comb begin
      diff_re   = DW'(sample_re_ff) - DW'($signed(rd_data[RAMW-1:POINT_WIDTH]));
      diff_im   = DW'(sample_im_ff) - DW'($signed(rd_data[POINT_WIDTH-1:0]));
      abs_re_in = diff_re[DW-1] ? DW'(-diff_re) : DW'(diff_re);
      abs_im_in = diff_im[DW-1] ? DW'(-diff_im) : DW'(diff_im);
      sq_re_in  = SQW'(abs_re_ff) * SQW'(abs_re_ff);
      sq_im_in  = SQW'(abs_im_ff) * SQW'(abs_im_ff);
      dist_sum  = DSTW'(sq_re_ff) + DSTW'(sq_im_ff);
      take      = (tag2_ff == '0) || (dist_sum < best_dist_ff);
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (v2_ff && take) begin
         best_dist_in = dist_sum;
         best_idx_in  = tag2_ff;
      end
      sym_wide = 9'(best_idx_in);
   end

   // item bookkeeping, held result and output register
   always_comb begin
      num_points_in = csr_fire ? csr_if.data : num_points_ff;
      issue_cnt_in  = issue_go ? issue_cnt_ff + CW'(1) : issue_cnt_ff;
      sample_re_in  = sample_re_ff;
      sample_im_in  = sample_im_ff;
      res_re_in     = res_re_ff;
      res_im_in     = res_im_ff;
      res_sym_in    = res_sym_ff;
      res_err_in    = res_err_ff;

      // start of an item: clear the result, latch the sample
      if (req_fire) begin
         issue_cnt_in = '0;
         sample_re_in = req_if.sample_re;
         sample_im_in = req_if.sample_im;
         res_re_in    = '0;
         res_im_in    = '0;
         res_sym_in   = '0;
         res_err_in   = ((req_if.op == OP_LOAD) || (req_if.op == OP_MAP)) && !idx_ok;
      end

      // map: take the point from the RAM read data
      if (state_ff == ST_MAP) begin
         res_re_in = $signed(rd_data[RAMW-1:POINT_WIDTH]);
         res_im_in = $signed(rd_data[POINT_WIDTH-1:0]);
      end

      // demap: the last point leaves the compare stage
      if ((state_ff == ST_SCAN) && v2_ff && last2_ff) begin
         res_sym_in = sym_wide[SYM_WIDTH-1:0];
      end

      // output register: load a finished result, drop a taken beat
      rsp_valid_in = rsp_valid_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_err_in   = rsp_err_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_re_in    = res_re_ff;
         rsp_im_in    = res_im_ff;
         rsp_sym_in   = res_sym_ff;
         rsp_err_in   = res_err_ff;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.mapped_re    = rsp_re_ff;
   assign rsp_if.mapped_im    = rsp_im_ff;
   assign rsp_if.symbol_index = rsp_sym_ff;
   assign rsp_if.index_error  = rsp_err_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_points_ff <= NUM_POINTS_RESET;
         issue_cnt_ff  <= '0;
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_points_ff <= num_points_in;
         issue_cnt_ff  <= issue_cnt_in;
         v0_ff         <= issue_go;
         v1_ff         <= v0_ff;
         v2_ff         <= v1_ff;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_re_ff <= sample_re_in;
      sample_im_ff <= sample_im_in;
      tag0_ff      <= issue_cnt_ff[AW-1:0];
      last0_ff     <= (issue_cnt_ff == eff_m - CW'(1));
      tag1_ff      <= tag0_ff;
      last1_ff     <= last0_ff;
      tag2_ff      <= tag1_ff;
      last2_ff     <= last1_ff;
      abs_re_ff    <= abs_re_in;
      abs_im_ff    <= abs_im_in;
      sq_re_ff     <= sq_re_in;
      sq_im_ff     <= sq_im_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      res_re_ff    <= res_re_in;
      res_im_ff    <= res_im_in;
      res_sym_ff   <= res_sym_in;
      res_err_ff   <= res_err_in;
      rsp_re_ff    <= rsp_re_in;
      rsp_im_ff    <= rsp_im_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // point table
   cmd_ram #(
      .WIDTH (RAMW),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // checks
   `CMD_ASSERT_NEXT(a_demap_start, clock, reset,
      req_fire && (req_if.op == OP_DEMAP),
      (state_ff == ST_SCAN) && (issue_cnt_ff == '0), "demap did not start a fresh scan")
   `CMD_ASSERT_NEXT(a_scan_end, clock, reset,
      (state_ff == ST_SCAN) && v2_ff && last2_ff,
      state_ff == ST_DONE, "scan did not finish on its last point")
   `CMD_ASSERT_IMPL(a_one_last, clock, reset, 1'b1,
      $onehot0({v0_ff && last0_ff, v1_ff && last1_ff, v2_ff && last2_ff}),
      "more than one last point in the distance pipeline")

endmodule
